FILE: rtl/plc_pkg.sv
`default_nettype none

package plc_pkg;

  // Phases of the lock controller.
  typedef enum logic [3:0] {
    PH_SETUP1     = 4'd0,
    PH_SETUP2     = 4'd1,
    PH_IDLE       = 4'd2,
    PH_LOGIN      = 4'd3,
    PH_OPENING    = 4'd4,
    PH_WAITMOTION = 4'd5,
    PH_CLOSING    = 4'd6,
    PH_VERIFY     = 4'd7,
    PH_LOCKOUT    = 4'd8
  } phase_t;

  // Classified input commands passed from the front end to the core.
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_MOTION = 2'd2
  } op_t;

  // Input mode codes as they arrive on the mode port.
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_MOTION = 2'd2;

  // Result kinds and motor commands.
  localparam logic       KIND_REPLY  = 1'b0;
  localparam logic       KIND_ACT    = 1'b1;
  localparam logic [1:0] MOTOR_STOP  = 2'd0;
  localparam logic [1:0] MOTOR_OPEN  = 2'd1;
  localparam logic [1:0] MOTOR_CLOSE = 2'd2;

  // Marker for a motion level that has not been seen yet.
  localparam logic [1:0] MOTION_UNKNOWN = 2'd3;

  // Protocol characters.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LOCK  = 8'h4C;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd0;
  localparam logic [1:0] REG_DOOR_TICKS    = 2'd1;
  localparam logic [1:0] REG_LOCKOUT_TICKS = 2'd2;
  localparam logic [3:0] RST_ATTEMPT_LIMIT = 4'd3;
  localparam logic [7:0] RST_DOOR_TICKS    = 8'd15;
  localparam logic [7:0] RST_LOCKOUT_TICKS = 8'd60;

  // Most results that one command can produce.
  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [3:0] attempt_limit;
    logic [7:0] door_ticks;
    logic [7:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] reply_byte;
    logic [1:0] motor_cmd;
    logic       buzzer;
    logic       last;
  } result_t;

  // Group of results caused by one command; cnt is the number in use.
  typedef struct packed {
    logic [1:0]                     cnt;
    result_t [MAX_RESULTS-1:0]      res;
  } group_t;

endpackage

`default_nettype wire

FILE: rtl/plc_front.sv
`default_nettype none

module plc_front
  import plc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] value,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_take
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       enq;
  logic       deq;
  cmd_t       classified;

  // Classify the incoming item; unused mode codes are accepted and dropped.
  always_comb begin
    classified = '{op: OP_BYTE, data: value};
    keep = 1'b1;
    unique case (mode)
      MODE_BYTE:   classified = '{op: OP_BYTE, data: value};
      MODE_TICK:   classified = '{op: OP_TICK, data: 8'd0};
      MODE_MOTION: classified = '{op: OP_MOTION, data: {7'd0, (value != 8'd0)}};
      default:     keep = 1'b0;
    endcase
  end

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign enq       = accept && keep;
  assign cmd_valid = (count != 2'd0);
  assign deq       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  // Two-entry command queue between the front end and the core.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= classified;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/plc_core.sv
`default_nettype none

module plc_core
  import plc_pkg::*;
#(
  parameter int CODE_LENGTH = 5
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      grp_valid,
  output group_t    grp,
  input  wire logic grp_ready
);

  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CODE_LENGTH - 1);

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] entry_index, entry_index_next;
  logic             mismatch_seen, mismatch_seen_next;
  logic [3:0]       fail_count, fail_count_next;
  logic [7:0]       tick_count, tick_count_next;
  logic [1:0]       prior_motion, prior_motion_next;
  logic             return_to_verify, return_to_verify_next;

  logic [7:0]       code_mem [CODE_LENGTH];
  logic [7:0]       code_rd;
  logic             fire;
  logic             code_wr;
  logic             entry_mode;
  logic             mism;
  logic             ok;
  logic [3:0]       fc_inc;
  logic [7:0]       tc_inc;
  logic             level;
  logic [1:0]       n;

  function automatic result_t mk_reply(input logic [7:0] b);
    mk_reply = '{kind: KIND_REPLY, reply_byte: b, motor_cmd: MOTOR_STOP,
                 buzzer: 1'b0, last: 1'b0};
  endfunction

  function automatic result_t mk_act(input logic [1:0] m, input logic bz);
    mk_act = '{kind: KIND_ACT, reply_byte: 8'd0, motor_cmd: m,
               buzzer: bz, last: 1'b0};
  endfunction

  assign fire      = cmd_valid && grp_ready;
  assign cmd_take  = fire;
  assign grp_valid = fire && (grp.cnt != 2'd0);
  assign code_rd   = code_mem[entry_index];
  assign fc_inc    = (fail_count != 4'd15) ? fail_count + 4'd1 : fail_count;
  assign tc_inc    = (tick_count != 8'hFF) ? tick_count + 8'd1 : tick_count;
  assign level     = cmd.data[0];
  assign entry_mode = (phase == PH_SETUP1) || (phase == PH_SETUP2) ||
                      (phase == PH_LOGIN) || (phase == PH_VERIFY);
  assign code_wr   = fire && (cmd.op == OP_BYTE) && (phase == PH_SETUP1);
  assign mism      = mismatch_seen || (code_rd != cmd.data);
  assign ok        = !mism;

  // Execute one command: next state and the results it produces.
  always_comb begin
    phase_next            = phase;
    entry_index_next      = entry_index;
    mismatch_seen_next    = mismatch_seen;
    fail_count_next       = fail_count;
    tick_count_next       = tick_count;
    prior_motion_next     = prior_motion;
    return_to_verify_next = return_to_verify;
    grp                   = '0;
    n                     = 2'd0;

    unique case (cmd.op)
      OP_BYTE: begin
        if (phase == PH_IDLE) begin
          if (cmd.data == CH_PLUS || cmd.data == CH_MINUS) begin
            fail_count_next    = 4'd0;
            tick_count_next    = 8'd0;
            entry_index_next   = '0;
            mismatch_seen_next = 1'b0;
            phase_next = (cmd.data == CH_PLUS) ? PH_LOGIN : PH_VERIFY;
          end
        end else if (entry_mode) begin
          if (entry_index != IDX_LAST) begin
            entry_index_next   = entry_index + IDX_W'(1);
            mismatch_seen_next = (phase == PH_SETUP1) ? mismatch_seen : mism;
          end else begin
            // The last byte of an entry closes it.
            entry_index_next   = '0;
            mismatch_seen_next = 1'b0;
            unique case (phase)
              PH_SETUP1: phase_next = PH_SETUP2;
              PH_SETUP2: begin
                grp.res[n] = mk_reply({7'd0, ok});
                n = n + 2'd1;
                phase_next = ok ? PH_IDLE : PH_SETUP1;
              end
              default: begin
                if (ok) begin
                  grp.res[n] = mk_reply(8'd1);
                  n = n + 2'd1;
                  grp.res[n] = mk_reply(CH_LOCK);
                  n = n + 2'd1;
                  if (phase == PH_LOGIN) begin
                    tick_count_next = 8'd0;
                    phase_next      = PH_OPENING;
                    grp.res[n] = mk_act(MOTOR_OPEN, 1'b0);
                    n = n + 2'd1;
                  end else begin
                    phase_next = PH_IDLE;
                  end
                end else begin
                  // Failed entry: count it and lock out at the limit.
                  grp.res[n] = mk_reply(8'd0);
                  n = n + 2'd1;
                  grp.res[n] = mk_reply(8'd0);
                  n = n + 2'd1;
                  fail_count_next = fc_inc;
                  if (fc_inc >= cfg.attempt_limit) begin
                    fail_count_next       = 4'd0;
                    tick_count_next       = 8'd0;
                    return_to_verify_next = (phase == PH_VERIFY);
                    phase_next            = PH_LOCKOUT;
                    grp.res[n] = mk_act(MOTOR_STOP, 1'b1);
                    n = n + 2'd1;
                  end
                end
              end
            endcase
          end
        end
      end
      OP_TICK: begin
        if (phase == PH_LOCKOUT) begin
          tick_count_next = tc_inc;
          if (tc_inc >= cfg.lockout_ticks) begin
            tick_count_next    = 8'd0;
            entry_index_next   = '0;
            mismatch_seen_next = 1'b0;
            phase_next = return_to_verify ? PH_VERIFY : PH_LOGIN;
            grp.res[n] = mk_act(MOTOR_STOP, 1'b0);
            n = n + 2'd1;
            grp.res[n] = mk_reply(8'd0);
            n = n + 2'd1;
          end
        end else if (phase == PH_OPENING || phase == PH_CLOSING) begin
          tick_count_next = tc_inc;
          if (tc_inc >= cfg.door_ticks) begin
            tick_count_next = 8'd0;
            grp.res[n] = mk_act(MOTOR_STOP, 1'b0);
            n = n + 2'd1;
            if (phase == PH_OPENING) begin
              prior_motion_next = MOTION_UNKNOWN;
              phase_next        = PH_WAITMOTION;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
      end
      OP_MOTION: begin
        if (phase == PH_WAITMOTION) begin
          if ({1'b0, level} != prior_motion) begin
            grp.res[n] = mk_reply({7'd0, level});
            n = n + 2'd1;
            prior_motion_next = {1'b0, level};
          end
          if (!level) begin
            grp.res[n] = mk_reply(8'd0);
            n = n + 2'd1;
            tick_count_next = 8'd0;
            phase_next      = PH_CLOSING;
            grp.res[n] = mk_act(MOTOR_CLOSE, 1'b0);
            n = n + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    grp.cnt = n;
    if (n != 2'd0) begin
      grp.res[n - 2'd1].last = 1'b1;
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SETUP1;
      entry_index      <= '0;
      mismatch_seen    <= 1'b0;
      fail_count       <= 4'd0;
      tick_count       <= 8'd0;
      prior_motion     <= MOTION_UNKNOWN;
      return_to_verify <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      entry_index      <= entry_index_next;
      mismatch_seen    <= mismatch_seen_next;
      fail_count       <= fail_count_next;
      tick_count       <= tick_count_next;
      prior_motion     <= prior_motion_next;
      return_to_verify <= return_to_verify_next;
    end
  end

  // Stored code, written during the first setup entry.
  always_ff @(posedge clk) begin
    if (code_wr) begin
      code_mem[entry_index] <= cmd.data;
    end
  end

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, entry_index} < (IDX_W + 1)'(CODE_LENGTH))
    else $error("entry index beyond code length");
  a_lockout_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LOCKOUT) |-> (fail_count == 4'd0))
    else $error("failure count not cleared during lockout");
`endif

endmodule

`default_nettype wire

FILE: rtl/plc_out.sv
`default_nettype none

module plc_out
  import plc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       grp_valid,
  input  wire group_t     grp,
  output logic            grp_ready,
  output logic            empty,
  input  wire logic       pop,
  output logic            kind,
  output logic [7:0]      reply_byte,
  output logic [1:0]      motor_cmd,
  output logic            buzzer,
  output logic            last
);

  logic                      busy;
  logic [1:0]                rd_idx;
  logic [1:0]                cnt;
  result_t [MAX_RESULTS-1:0] res;
  result_t                   cur;
  logic                      at_last;
  logic                      load;

  assign at_last   = (rd_idx == cnt - 2'd1);
  assign grp_ready = !busy || (pop && at_last);
  assign load      = grp_valid && grp_ready;
  assign empty     = !busy;
  assign cur       = res[rd_idx];

  assign kind       = cur.kind;
  assign reply_byte = cur.reply_byte;
  assign motor_cmd  = cur.motor_cmd;
  assign buzzer     = cur.buzzer;
  assign last       = cur.last;

  // Walk through the held group one transfer at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rd_idx <= 2'd0;
      cnt    <= 2'd0;
    end else if (load) begin
      busy   <= 1'b1;
      rd_idx <= 2'd0;
      cnt    <= grp.cnt;
    end else if (busy && pop) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= grp.res;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != 2'd0 && rd_idx < cnt))
    else $error("result index outside held group");
`endif

endmodule

`default_nettype wire

FILE: rtl/password_lock_controller.sv
// Items enter a two-entry command queue that separates the input side from the core and result
// stage, at one per cycle while full is low. The core loads an item's results into the result
// stage register that drives the ports; results leave at one per cycle while pop is high.
// An item that causes k results (at most 3) holds the core until its last result is popped.
// Reset (rst, synchronous, active high) clears all control state, loads the registers with
// 3, 15 and 60 and starts in the first setup entry; the stored code is not cleared.
`default_nettype none

module password_lock_controller
  import plc_pkg::*;
#(
  parameter int CODE_LENGTH = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] value,
  output logic            empty,
  input  wire logic       pop,
  output logic            kind,
  output logic [7:0]      reply_byte,
  output logic [1:0]      motor_cmd,
  output logic            buzzer,
  output logic            last,
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t   cfg;
  logic   cmd_valid;
  cmd_t   cmd;
  logic   cmd_take;
  logic   grp_valid;
  group_t grp;
  logic   grp_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attempt_limit <= RST_ATTEMPT_LIMIT;
      cfg.door_ticks    <= RST_DOOR_TICKS;
      cfg.lockout_ticks <= RST_LOCKOUT_TICKS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ATTEMPT_LIMIT: cfg.attempt_limit <= cfg_data[3:0];
        REG_DOOR_TICKS:    cfg.door_ticks    <= cfg_data;
        REG_LOCKOUT_TICKS: cfg.lockout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  plc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  plc_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready)
  );

  plc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .grp_valid  (grp_valid),
    .grp        (grp),
    .grp_ready  (grp_ready),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .reply_byte (reply_byte),
    .motor_cmd  (motor_cmd),
    .buzzer     (buzzer),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_password_lock_controller.sv
`default_nettype none

module tb_password_lock_controller;
  import plc_pkg::*;

  localparam int CODE_LEN = 5;
  localparam int DIR_ROWS = 24;
  localparam int NUM_SETTINGS = 6;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Clock and DUT ports.
  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] mode;
  logic [7:0] value;
  logic       empty;
  logic       pop;
  logic       kind;
  logic [7:0] reply_byte;
  logic [1:0] motor_cmd;
  logic       buzzer;
  logic       last;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  password_lock_controller #(
    .CODE_LENGTH(CODE_LEN)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .value      (value),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .reply_byte (reply_byte),
    .motor_cmd  (motor_cmd),
    .buzzer     (buzzer),
    .last       (last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // One row of the directed stimulus; typed rows carry their own expectation.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] value;
    logic       typed;
    logic [1:0] n_typed;
    logic [7:0] typed_byte;
  } stim_row_t;

  // One register setting and the random traffic that runs under it.
  typedef struct packed {
    logic [3:0] attempts;
    logic [7:0] door;
    logic [7:0] lockout;
    logic [6:0] bad_pct;
    logic [9:0] quota;
  } setting_t;

  stim_row_t stim_tab [DIR_ROWS];
  setting_t  settings_tab [NUM_SETTINGS];
  logic [7:0] dir_code [CODE_LEN];

  // Shadow state of the lock controller.
  phase_t     lk_phase;
  logic [7:0] lk_code [CODE_LEN];
  logic [2:0] entry_pos;
  logic       entry_bad;
  logic [3:0] fails;
  logic [7:0] ticks;
  logic [1:0] last_motion;
  logic       back_to_verify;
  logic [3:0] cfg_attempts;
  logic [7:0] cfg_door;
  logic [7:0] cfg_lockout;

  // Results of the current item, and the results still owed by the DUT.
  result_t step_out [$];
  result_t owed_q [$];
  result_t want_res;

  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned stall_cycles;
  int unsigned bad_pct;
  bit          entry_good;

  task automatic note_reply(input logic [7:0] b);
    result_t r;
    r.kind       = KIND_REPLY;
    r.reply_byte = b;
    r.motor_cmd  = MOTOR_STOP;
    r.buzzer     = 1'b0;
    r.last       = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic note_act(input logic [1:0] motor, input logic buzz);
    result_t r;
    r.kind       = KIND_ACT;
    r.reply_byte = 8'h00;
    r.motor_cmd  = motor;
    r.buzzer     = buzz;
    r.last       = 1'b0;
    step_out.push_back(r);
  endtask

  // A failed entry: two zero replies, and a lockout once the limit is reached.
  task automatic entry_fail(input logic verifying);
    note_reply(8'h00);
    if (fails < 4'd15) fails = fails + 4'd1;
    note_reply(8'h00);
    if (fails >= cfg_attempts) begin
      fails = 4'd0;
      ticks = 8'd0;
      back_to_verify = verifying;
      lk_phase = PH_LOCKOUT;
      note_act(MOTOR_STOP, 1'b1);
    end
  endtask

  // A full code has been entered in the current phase.
  task automatic entry_complete();
    logic ok;
    ok = !entry_bad;
    entry_bad = 1'b0;
    case (lk_phase)
      PH_SETUP1: begin
        lk_phase = PH_SETUP2;
      end
      PH_SETUP2: begin
        note_reply(ok ? 8'd1 : 8'd0);
        lk_phase = ok ? PH_IDLE : PH_SETUP1;
      end
      PH_LOGIN: begin
        if (ok) begin
          note_reply(8'd1);
          note_reply(CH_LOCK);
          ticks = 8'd0;
          lk_phase = PH_OPENING;
          note_act(MOTOR_OPEN, 1'b0);
        end else begin
          entry_fail(1'b0);
        end
      end
      default: begin
        if (ok) begin
          note_reply(8'd1);
          note_reply(CH_LOCK);
          lk_phase = PH_IDLE;
        end else begin
          entry_fail(1'b1);
        end
      end
    endcase
  endtask

  // Predicts the results of one accepted item into step_out.
  task automatic lock_predict(input logic [1:0] m, input logic [7:0] v);
    logic    level;
    result_t tail;
    step_out.delete();
    case (m)
      MODE_BYTE: begin
        if (lk_phase == PH_IDLE) begin
          if (v == CH_PLUS || v == CH_MINUS) begin
            fails = 4'd0;
            ticks = 8'd0;
            entry_pos = 3'd0;
            entry_bad = 1'b0;
            lk_phase = (v == CH_PLUS) ? PH_LOGIN : PH_VERIFY;
          end
        end else if (lk_phase == PH_SETUP1 || lk_phase == PH_SETUP2 ||
                     lk_phase == PH_LOGIN || lk_phase == PH_VERIFY) begin
          if (entry_pos >= CODE_LEN) entry_pos = 3'd0;
          if (lk_phase == PH_SETUP1) lk_code[entry_pos] = v;
          else if (lk_code[entry_pos] != v) entry_bad = 1'b1;
          entry_pos = entry_pos + 3'd1;
          if (entry_pos >= CODE_LEN) begin
            entry_pos = 3'd0;
            entry_complete();
          end
        end
      end
      MODE_TICK: begin
        if (lk_phase == PH_OPENING || lk_phase == PH_CLOSING ||
            lk_phase == PH_LOCKOUT) begin
          if (ticks < 8'd255) ticks = ticks + 8'd1;
          if (lk_phase == PH_LOCKOUT) begin
            if (ticks >= cfg_lockout) begin
              ticks = 8'd0;
              note_act(MOTOR_STOP, 1'b0);
              note_reply(8'h00);
              entry_pos = 3'd0;
              entry_bad = 1'b0;
              lk_phase = back_to_verify ? PH_VERIFY : PH_LOGIN;
            end
          end else if (ticks >= cfg_door) begin
            ticks = 8'd0;
            note_act(MOTOR_STOP, 1'b0);
            if (lk_phase == PH_OPENING) begin
              last_motion = MOTION_UNKNOWN;
              lk_phase = PH_WAITMOTION;
            end else begin
              lk_phase = PH_IDLE;
            end
          end
        end
      end
      MODE_MOTION: begin
        level = (v != 8'h00);
        if (lk_phase == PH_WAITMOTION) begin
          if ({1'b0, level} != last_motion) begin
            note_reply({7'd0, level});
            last_motion = {1'b0, level};
          end
          if (!level) begin
            note_reply(8'h00);
            ticks = 8'd0;
            lk_phase = PH_CLOSING;
            note_act(MOTOR_CLOSE, 1'b0);
          end
        end
      end
      default: begin
      end
    endcase
    if (step_out.size() > 0) begin
      tail = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
    end
  endtask

  // Chooses the next random item from the shadow phase; noise items do not count.
  task automatic pick_item(output logic [1:0] m, output logic [7:0] v, output bit counts);
    int unsigned r;
    r = $urandom_range(99);
    counts = 1'b1;
    m = MODE_UNUSED;
    v = 8'h00;
    case (lk_phase)
      PH_IDLE: begin
        if (r < 45) begin
          m = MODE_BYTE;
          v = CH_PLUS;
        end else if (r < 75) begin
          m = MODE_BYTE;
          v = CH_MINUS;
        end else begin
          counts = 1'b0;
        end
      end
      PH_SETUP1, PH_SETUP2, PH_LOGIN, PH_VERIFY: begin
        if (r < 8) begin
          counts = 1'b0;
        end else begin
          if (entry_pos == 3'd0) entry_good = ($urandom_range(99) >= bad_pct);
          m = MODE_BYTE;
          v = lk_code[entry_pos];
          if (!entry_good && $urandom_range(1) == 1) v = 8'($urandom_range(255));
        end
      end
      PH_OPENING, PH_CLOSING, PH_LOCKOUT: begin
        if (r < 90) m = MODE_TICK;
        else counts = 1'b0;
      end
      PH_WAITMOTION: begin
        if (r < 75) begin
          m = MODE_MOTION;
          v = ($urandom_range(99) < 35) ? 8'h00 : 8'($urandom_range(255, 1));
        end else begin
          counts = 1'b0;
        end
      end
      default: begin
        counts = 1'b0;
      end
    endcase
    if (!counts) begin
      m = 2'($urandom_range(3));
      v = 8'($urandom_range(255));
    end
  endtask

  // Offers one item after a random gap and waits for its transfer.
  task automatic transfer_item(input logic [1:0] m, input logic [7:0] v);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    mode  <= m;
    value <= v;
    do @(posedge clk); while (full);
  endtask

  // Stops sending, waits for every owed result, then lets the core settle.
  task automatic drain();
    push <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: check each transfer against the oldest owed result, then stall at random.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        checked_count = checked_count + 1;
        if (owed_q.size() == 0) begin
          $error("result with nothing owed: kind %0d byte %0h", kind, reply_byte);
          error_count = error_count + 1;
        end else begin
          want_res = owed_q.pop_front();
          if (kind !== want_res.kind) begin
            $error("kind: expected %0d, got %0d", want_res.kind, kind);
            error_count = error_count + 1;
          end
          if (reply_byte !== want_res.reply_byte) begin
            $error("reply_byte: expected %0h, got %0h", want_res.reply_byte, reply_byte);
            error_count = error_count + 1;
          end
          if (motor_cmd !== want_res.motor_cmd) begin
            $error("motor_cmd: expected %0d, got %0d", want_res.motor_cmd, motor_cmd);
            error_count = error_count + 1;
          end
          if (buzzer !== want_res.buzzer) begin
            $error("buzzer: expected %0d, got %0d", want_res.buzzer, buzzer);
            error_count = error_count + 1;
          end
          if (last !== want_res.last) begin
            $error("last: expected %0d, got %0d", want_res.last, last);
            error_count = error_count + 1;
          end
        end
      end
      pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_password_lock_controller failed");
        $finish;
      end
    end
  end

  initial begin
    int          i;
    int          p;
    logic [1:0]  m;
    logic [7:0]  v;
    bit          counts;
    int unsigned done;
    int unsigned random_items;
    result_t     typed_res;

    rst       <= 1'b1;
    push      <= 1'b0;
    mode      <= MODE_BYTE;
    value     <= 8'h00;
    cfg_write <= 1'b0;
    cfg_index <= REG_ATTEMPT_LIMIT;
    cfg_data  <= 8'h00;
    error_count   = 0;
    checked_count = 0;
    stall_cycles  = 0;
    random_items  = 0;
    entry_good    = 1'b1;
    bad_pct       = 40;
    tx_idle       = 34;
    rx_idle       = 69;

    // Shadow state after reset.
    lk_phase       = PH_SETUP1;
    entry_pos      = 3'd0;
    entry_bad      = 1'b0;
    fails          = 4'd0;
    ticks          = 8'd0;
    last_motion    = MOTION_UNKNOWN;
    back_to_verify = 1'b0;
    cfg_attempts   = RST_ATTEMPT_LIMIT;
    cfg_door       = RST_DOOR_TICKS;
    cfg_lockout    = RST_LOCKOUT_TICKS;
    for (i = 0; i < CODE_LEN; i++) lk_code[i] = 8'h00;

    // Directed part: inputs ignored after reset, a failed then a good setup, then '-'.
    dir_code = '{8'h00, 8'hFF, CH_PLUS, CH_MINUS, 8'h80};
    stim_tab[0] = '{MODE_UNUSED, 8'hAA, 1'b1, 2'd0, 8'h00};
    stim_tab[1] = '{MODE_TICK, 8'h55, 1'b1, 2'd0, 8'h00};
    stim_tab[2] = '{MODE_MOTION, 8'h01, 1'b1, 2'd0, 8'h00};
    for (i = 0; i < CODE_LEN; i++) begin
      stim_tab[3 + i]  = '{MODE_BYTE, dir_code[i], 1'b0, 2'd0, 8'h00};
      stim_tab[8 + i]  = '{MODE_BYTE, dir_code[i], 1'b0, 2'd0, 8'h00};
      stim_tab[13 + i] = '{MODE_BYTE, dir_code[i], 1'b0, 2'd0, 8'h00};
      stim_tab[18 + i] = '{MODE_BYTE, dir_code[i], 1'b0, 2'd0, 8'h00};
    end
    // Mismatched re-entry answers 0; matching re-entry answers 1.
    stim_tab[12] = '{MODE_BYTE, 8'h81, 1'b1, 2'd1, 8'h00};
    stim_tab[22] = '{MODE_BYTE, dir_code[4], 1'b1, 2'd1, 8'h01};
    stim_tab[23] = '{MODE_BYTE, CH_MINUS, 1'b0, 2'd0, 8'h00};

    // Register settings: reset values, the low and high ends, zero, and a mix.
    settings_tab[0] = '{4'd3, 8'd15, 8'd60, 7'd40, 10'd45};
    settings_tab[1] = '{4'd1, 8'd1, 8'd1, 7'd50, 10'd45};
    settings_tab[2] = '{4'd15, 8'd2, 8'd3, 7'd92, 10'd55};
    settings_tab[3] = '{4'd0, 8'd0, 8'd0, 7'd50, 10'd45};
    settings_tab[4] = '{4'd2, 8'd255, 8'd255, 7'd10, 10'd130};
    settings_tab[5] = '{4'd4, 8'd4, 8'd5, 7'd45, 10'd50};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      transfer_item(stim_tab[i].mode, stim_tab[i].value);
      lock_predict(stim_tab[i].mode, stim_tab[i].value);
      if (stim_tab[i].typed) begin
        if (stim_tab[i].n_typed != 2'd0) begin
          typed_res.kind       = KIND_REPLY;
          typed_res.reply_byte = stim_tab[i].typed_byte;
          typed_res.motor_cmd  = MOTOR_STOP;
          typed_res.buzzer     = 1'b0;
          typed_res.last       = 1'b1;
          owed_q.push_back(typed_res);
        end
      end else begin
        foreach (step_out[k]) owed_q.push_back(step_out[k]);
      end
    end

    // Random part, one register setting per phase; idling changes every two phases.
    for (p = 0; p < NUM_SETTINGS; p++) begin
      case (p / 2)
        0: begin
          tx_idle = 34;
          rx_idle = 69;
        end
        1: begin
          tx_idle = 69;
          rx_idle = 34;
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
        end
      endcase
      drain();
      cfg_write <= 1'b1;
      cfg_index <= REG_ATTEMPT_LIMIT;
      cfg_data  <= {4'd0, settings_tab[p].attempts};
      @(posedge clk);
      cfg_index <= REG_DOOR_TICKS;
      cfg_data  <= settings_tab[p].door;
      @(posedge clk);
      cfg_index <= REG_LOCKOUT_TICKS;
      cfg_data  <= settings_tab[p].lockout;
      @(posedge clk);
      cfg_write <= 1'b0;
      cfg_attempts = settings_tab[p].attempts;
      cfg_door     = settings_tab[p].door;
      cfg_lockout  = settings_tab[p].lockout;
      bad_pct      = settings_tab[p].bad_pct;

      done = 0;
      while (done < settings_tab[p].quota) begin
        pick_item(m, v, counts);
        transfer_item(m, v);
        lock_predict(m, v);
        foreach (step_out[k]) owed_q.push_back(step_out[k]);
        random_items = random_items + 1;
        if (counts) done = done + 1;
      end
    end

    drain();
    $display("Ran %0d directed and %0d random items over %0d register settings.",
             DIR_ROWS, random_items, NUM_SETTINGS);
    $display("Compared %0d results covering setup, login, verify, door cycles and lockouts.",
             checked_count);
    if (error_count == 0) begin
      $display("tb_password_lock_controller passed");
    end else begin
      $display("tb_password_lock_controller failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/plc_pkg.sv
rtl/plc_front.sv
rtl/plc_core.sv
rtl/plc_out.sv
rtl/password_lock_controller.sv
tb/sv/tb_password_lock_controller.sv
